@@ design/dwm_pkg.sv @@
package dwm_pkg;

  localparam int NUM_MATCHPOINTS = 8;
  localparam int NUM_WATCHPOINTS = 11;
  localparam int DATA_WIDTH      = 32;
  localparam int COUNTER_WIDTH   = 16;

  localparam int MP_SLOTS   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MODE_W     = 24;
  localparam int WCTL_W     = 24;
  localparam int TGT_W      = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VPAIR_01    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VPAIR_23    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VPAIR_45    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VPAIR_67    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_CTL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WATCH_CTL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_TARGETS = 3'd7;

  // access kinds
  localparam logic [2:0] KIND_FETCH_ADDR = 3'd0;
  localparam logic [2:0] KIND_LOAD_ADDR  = 3'd1;
  localparam logic [2:0] KIND_STORE_ADDR = 3'd2;
  localparam logic [2:0] KIND_LOAD_DATA  = 3'd3;
  localparam logic [2:0] KIND_STORE_DATA = 3'd4;

  // compare conditions
  localparam logic [2:0] COND_MASKED = 3'd0;
  localparam logic [2:0] COND_EQ     = 3'd1;
  localparam logic [2:0] COND_LT     = 3'd2;
  localparam logic [2:0] COND_LE     = 3'd3;
  localparam logic [2:0] COND_GT     = 3'd4;
  localparam logic [2:0] COND_GE     = 3'd5;
  localparam logic [2:0] COND_NE     = 3'd6;

  // compare targets
  localparam logic [2:0] TGT_FETCH_ADDR = 3'd1;
  localparam logic [2:0] TGT_LOAD_ADDR  = 3'd2;
  localparam logic [2:0] TGT_STORE_ADDR = 3'd3;
  localparam logic [2:0] TGT_LOAD_DATA  = 3'd4;
  localparam logic [2:0] TGT_STORE_DATA = 3'd5;
  localparam logic [2:0] TGT_LS_ADDR    = 3'd6;
  localparam logic [2:0] TGT_LS_DATA    = 3'd7;

  // chain modes
  localparam logic [1:0] CHAIN_PLAIN = 2'd0;
  localparam logic [1:0] CHAIN_AND   = 2'd1;
  localparam logic [1:0] CHAIN_OR    = 2'd2;

  typedef struct packed {
    logic [2:0]  access_kind;
    logic [31:0] access_value;
    logic        new_cycle;
  } dwm_in_t;

  typedef struct packed {
    logic        stop_cpu;
    logic [10:0] fired_bits;
    logic [15:0] count_zero;
    logic [15:0] count_one;
  } dwm_out_t;

endpackage

@@ design/dwm_in_if.sv @@
interface dwm_in_if;
  logic             valid;
  logic             ready;
  dwm_pkg::dwm_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/dwm_out_if.sv @@
interface dwm_out_if;
  logic              valid;
  logic              ready;
  dwm_pkg::dwm_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/debug_watchpoint_matcher.sv @@
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | access_kind, access_value, new_cycle
// out_ch   | out | valid/ready        | stop_cpu, fired_bits, count_zero, count_one
// cfg_*    | in  | cfg_we, no ready   | cfg_idx, cfg_data
//
// An accepted request is held in the input register, then makes one pass
// through the matchpoint compares and the watchpoint chain into the result register.
// One request per cycle sustained unless the output stalls; the fired record and both
// counters update as the result register loads. A stalled result holds the input
// register, which still takes a request if the output frees in the same cycle.
// Reset (rst_n low, synchronous) empties both stages and clears state and config.
module debug_watchpoint_matcher (
  input  logic                                   clk,
  input  logic                                   rst_n,
  dwm_in_if.sink                                 in_ch,
  dwm_out_if.source                              out_ch,
  input  logic                                   cfg_we,
  input  logic [dwm_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [dwm_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int DW = dwm_pkg::DATA_WIDTH;
  localparam int CW = dwm_pkg::COUNTER_WIDTH;
  localparam int NW = dwm_pkg::NUM_WATCHPOINTS;

  // configuration
  logic [dwm_pkg::CFG_DATA_W-1:0] vpair_r [4];
  logic [dwm_pkg::CFG_DATA_W-1:0] match_ctl_r;
  logic [dwm_pkg::MODE_W-1:0]     mode_r;
  logic [dwm_pkg::WCTL_W-1:0]     wctl_r;
  logic [dwm_pkg::TGT_W-1:0]      tgt_r;

  // pipeline
  logic                 s1_valid_r;
  dwm_pkg::dwm_in_t     s1_data_r;
  logic                 out_valid_r;
  dwm_pkg::dwm_out_t    out_data_r;
  logic                 advance;

  // state
  logic [NW-1:0]        fired_r;
  logic [CW-1:0]        cnt_a_r;
  logic [CW-1:0]        cnt_b_r;

  logic [NW-1:0]        fired_nxt;
  logic [CW-1:0]        cnt_a_nxt;
  logic [CW-1:0]        cnt_b_nxt;
  logic                 stop_nxt;

  function automatic logic target_applies(input logic [2:0] kind, input logic [2:0] ct);
    logic r;
    case (kind)
      dwm_pkg::KIND_FETCH_ADDR: r = (ct == dwm_pkg::TGT_FETCH_ADDR);
      dwm_pkg::KIND_LOAD_ADDR:  r = (ct == dwm_pkg::TGT_LOAD_ADDR) ||
                                    (ct == dwm_pkg::TGT_LS_ADDR);
      dwm_pkg::KIND_STORE_ADDR: r = (ct == dwm_pkg::TGT_STORE_ADDR) ||
                                    (ct == dwm_pkg::TGT_LS_ADDR);
      dwm_pkg::KIND_LOAD_DATA:  r = (ct == dwm_pkg::TGT_LOAD_DATA) ||
                                    (ct == dwm_pkg::TGT_LS_DATA);
      dwm_pkg::KIND_STORE_DATA: r = (ct == dwm_pkg::TGT_STORE_DATA) ||
                                    (ct == dwm_pkg::TGT_LS_DATA);
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic mp_match(input logic [7:0] ctl, input logic [2:0] kind,
                                    input logic [DW-1:0] val, input logic [DW-1:0] ref_v);
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          r;
    a = {val[DW-1] ^ ctl[4], val[DW-2:0]};
    b = {ref_v[DW-1] ^ ctl[4], ref_v[DW-2:0]};
    case (ctl[3:1])
      dwm_pkg::COND_MASKED: r = (val & ref_v) != '0;
      dwm_pkg::COND_EQ:     r = (val == ref_v);
      dwm_pkg::COND_LT:     r = (a < b);
      dwm_pkg::COND_LE:     r = (a <= b);
      dwm_pkg::COND_GT:     r = (a > b);
      dwm_pkg::COND_GE:     r = (a >= b);
      dwm_pkg::COND_NE:     r = (val != ref_v);
      default:              r = 1'b0;
    endcase
    return ctl[0] && target_applies(kind, ctl[7:5]) && r;
  endfunction

  function automatic logic chain_fn(input logic [1:0] cm, input logic c1, input logic c2);
    logic r;
    case (cm)
      dwm_pkg::CHAIN_PLAIN: r = c1;
      dwm_pkg::CHAIN_AND:   r = c1 & c2;
      dwm_pkg::CHAIN_OR:    r = c1 | c2;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        vpair_r[k] <= '0;
      end
      match_ctl_r <= '0;
      mode_r      <= '0;
      wctl_r      <= '0;
      tgt_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        dwm_pkg::REG_VPAIR_01:    vpair_r[0]  <= cfg_data;
        dwm_pkg::REG_VPAIR_23:    vpair_r[1]  <= cfg_data;
        dwm_pkg::REG_VPAIR_45:    vpair_r[2]  <= cfg_data;
        dwm_pkg::REG_VPAIR_67:    vpair_r[3]  <= cfg_data;
        dwm_pkg::REG_MATCH_CTL:   match_ctl_r <= cfg_data;
        dwm_pkg::REG_MODE:        mode_r      <= cfg_data[dwm_pkg::MODE_W-1:0];
        dwm_pkg::REG_WATCH_CTL:   wctl_r      <= cfg_data[dwm_pkg::WCTL_W-1:0];
        dwm_pkg::REG_CNT_TARGETS: tgt_r       <= cfg_data[dwm_pkg::TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // evaluation
  logic [dwm_pkg::MP_SLOTS-1:0] mp_hit;
  logic [NW-1:0]                m;
  logic [NW-1:0]                first;
  logic [NW-1:0]                fired_base;
  logic [NW-1:0]                sel_b;
  logic                         eval_en;
  logic                         single_step;
  logic [CW-1:0]                cnt_a8;
  logic [CW-1:0]                cnt_b9;
  logic [CW-1:0]                tgt_a;
  logic [CW-1:0]                tgt_b;

  always_comb begin
    mp_hit = '0;
    for (int i = 0; i < dwm_pkg::NUM_MATCHPOINTS; i++) begin
      mp_hit[i] = mp_match(match_ctl_r[8*i +: 8], s1_data_r.access_kind,
                           s1_data_r.access_value[DW-1:0],
                           vpair_r[i/2][32*(i%2) +: DW]);
    end
  end

  assign fired_base  = s1_data_r.new_cycle ? '0 : fired_r;
  assign single_step = mode_r[1] && mode_r[0] &&
                       (s1_data_r.access_kind == dwm_pkg::KIND_FETCH_ADDR);
  assign eval_en     = mode_r[1] && !single_step && (wctl_r[23:2] != '0);
  assign sel_b       = wctl_r[2 +: NW];
  assign tgt_a       = tgt_r[CW-1:0];
  assign tgt_b       = tgt_r[16 +: CW];

  always_comb begin
    m    = '0;
    m[0] = chain_fn(mode_r[3:2], mp_hit[0], mp_hit[0]);
    for (int i = 1; i < 8; i++) begin
      m[i] = chain_fn(mode_r[2+2*i +: 2], mp_hit[i], fired_base[i-1] | m[i-1]);
    end
    first[7:0] = m[7:0] & ~fired_base[7:0];
    cnt_a8 = cnt_a_r + (wctl_r[0] ? CW'($countones(first[7:0] & ~sel_b[7:0])) : '0);
    m[8] = chain_fn(mode_r[19:18], cnt_a8 == tgt_a, fired_base[7] | m[7]);
    first[8] = m[8] & ~fired_base[8];
    cnt_b9 = cnt_b_r + (wctl_r[1] ? CW'($countones(first[8:0] & sel_b[8:0])) : '0);
    m[9] = chain_fn(mode_r[21:20], cnt_b9 == tgt_b, fired_base[8] | m[8]);
    // external watchpoint never matches
    m[10] = 1'b0;
    if (!eval_en) begin
      m = '0;
    end
    first = m & ~fired_base;
    fired_nxt = fired_base | m;
    cnt_a_nxt = cnt_a_r + (wctl_r[0] ? CW'($countones(first & ~sel_b)) : '0);
    cnt_b_nxt = cnt_b_r + (wctl_r[1] ? CW'($countones(first & sel_b)) : '0);
    stop_nxt  = single_step || ((m & wctl_r[13 +: NW]) != '0);
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fired_r     <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && advance) begin
        fired_r <= fired_nxt;
        cnt_a_r <= cnt_a_nxt;
        cnt_b_r <= cnt_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
    if (s1_valid_r && advance) begin
      out_data_r.stop_cpu   <= stop_nxt;
      out_data_r.fired_bits <= fired_nxt;
      out_data_r.count_zero <= 16'(cnt_a_nxt);
      out_data_r.count_one  <= 16'(cnt_b_nxt);
    end
  end

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output drains");

  a_ext_never_fires: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.data.fired_bits[10])
    else $error("external watchpoint fired");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (wctl_r[1:0] == 2'b00)) |=>
      (cnt_a_r == $past(cnt_a_r)) && (cnt_b_r == $past(cnt_b_r)))
    else $error("counter moved while disabled");

endmodule
